[rtl/salc_pkg.sv]
`timescale 1ns / 1ps

package salc_pkg;

    localparam int ADDRESS_BITS     = 48;
    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int AGE_W            = 3;
    localparam int TOTAL_W          = 32;
    localparam int HITS_W           = 2;
    localparam int SET_BITS_W       = 3;
    localparam int OFFSET_W         = 5;
    localparam int WAYS_W           = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_FETCH  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ADDRESS_BITS-1:0] address;
    } req_t;

    typedef struct packed {
        logic [HITS_W-1:0]  hits;
        logic               missed;
        logic               evicted;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
        logic [TOTAL_W-1:0] total_evictions;
    } rsp_t;

    typedef struct packed {
        logic                    valid;
        logic [AGE_W-1:0]        age;
        logic [ADDRESS_BITS-1:0] tag;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    typedef struct packed {
        logic start;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic fetch;
    } dp_status_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] age);
        age_inc = (age == AGE_MAX) ? age : age + 1'b1;
    endfunction

endpackage

[rtl/set_assoc_lru_cache_sim.sv]
`timescale 1ns / 1ps

// Set-associative cache hit/miss model with per-line LRU ages. Each req
// transaction carries an access kind and a byte address; the address is split
// by block_offset_bits and set_index_bits into set index and tag, all in-use
// ways of the set are compared in parallel, and one rsp transaction reports
// the hits, miss and eviction of that access plus the running 32-bit totals.
// Instruction fetches are accepted and dropped with no rsp. Misses fill the
// lowest empty way, or else evict the oldest way (lowest way on a tie). The
// tag store is one single-port row memory, one row per set holding valid,
// age and tag of every way; each access is one read and one write-back of its
// row, done as accept + read, then update + write-back; the block takes no new
// access until that write-back is done. A full output register stalls the
// update cycle until the held rsp is taken. Per-set written flags cleared at
// reset make the store read empty right after reset, so no clearing pass is
// needed. Configuration writes are always taken (cfg_ready is tied high);
// write them only while no access is in flight. A cfg_index beyond the
// register list is ignored.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  salc_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output salc_pkg::rsp_t                  rsp
);
    import salc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration registers never back-pressure
    assign cfg_ready = 1'b1;

    // sequence each access: accept/read, then update/write-back
    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // address split, tag store, LRU update, totals and output register
    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp)
    );

endmodule

[rtl/salc_ctrl.sv]
`timescale 1ns / 1ps

module salc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  salc_pkg::dp_status_t status,
    output salc_pkg::dp_cmd_t    cmd
);
    import salc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !status.fetch)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.start  = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid && !status.fetch;
            end
            ST_LOOKUP:
            begin
                // hold the result until the output register is free
                cmd.commit = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/salc_dp.sv]
`timescale 1ns / 1ps

module salc_dp #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  salc_pkg::req_t                      req,
    input  salc_pkg::dp_cmd_t                   cmd,
    output salc_pkg::dp_status_t                status,
    output salc_pkg::rsp_t                      rsp
);
    import salc_pkg::*;

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_ROWS  = 1 << SET_IDX_W;
    localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W     = MAX_WAYS * LINE_W;

    // configuration
    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [OFFSET_W-1:0]   offset_bits_reg;
    logic [WAYS_W-1:0]     ways_reg;

    // access latched at accept
    logic                    modify_reg;
    logic [SET_IDX_W-1:0]    set_reg;
    logic [ADDRESS_BITS-1:0] tag_reg;
    logic                    row_known_reg;

    // tag store
    logic [ROW_W-1:0]    mem [NUM_ROWS];
    logic [ROW_W-1:0]    rd_row_reg;
    logic [NUM_ROWS-1:0] row_written_reg;

    logic [TOTAL_W-1:0] hit_total_reg;
    logic [TOTAL_W-1:0] miss_total_reg;
    logic [TOTAL_W-1:0] evict_total_reg;
    rsp_t               rsp_reg;

    logic [SET_BITS_W-1:0]   eff_set_bits;
    logic [ADDRESS_BITS-1:0] offset_shifted;
    logic [SET_IDX_W-1:0]    set_mask;
    logic [SET_IDX_W-1:0]    set_idx;
    logic [ADDRESS_BITS-1:0] tag_in;

    line_t                 old_line [MAX_WAYS];
    line_t                 new_line [MAX_WAYS];
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   hit_vec;
    logic [MAX_WAYS-1:0]   empty_vec;
    logic [WAY_IDX_W-1:0]  hit_way;
    logic [WAY_IDX_W-1:0]  empty_way;
    logic [WAY_IDX_W-1:0]  victim_way;
    logic [WAY_IDX_W-1:0]  target_way;
    logic [AGE_W-1:0]      hit_age;
    logic                  any_hit;
    logic                  any_empty;
    logic [ROW_W-1:0]      wr_row;
    logic [HITS_W-1:0]     hits;
    logic                  missed;
    logic                  evicted;

    assign status.fetch = (req.opcode == OP_FETCH);

    // split the address into set index and tag
    always_comb
    begin
        eff_set_bits   = (set_bits_reg > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS)
                                                       : set_bits_reg;
        offset_shifted = req.address >> offset_bits_reg;
        set_mask       = ~({SET_IDX_W{1'b1}} << eff_set_bits);
        set_idx        = offset_shifted[SET_IDX_W-1:0] & set_mask;
        tag_in         = offset_shifted >> eff_set_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= '0;
            offset_bits_reg <= '0;
            ways_reg        <= WAYS_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SET_BITS:    set_bits_reg    <= cfg_data[SET_BITS_W-1:0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[OFFSET_W-1:0];
                CFG_WAYS:        ways_reg        <= cfg_data[WAYS_W-1:0];
                default:         set_bits_reg    <= set_bits_reg;
            endcase
        end
    end

    // set lookup, replacement choice and age update
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            old_line[w] = line_t'(rd_row_reg[w*LINE_W +: LINE_W]);
            if (!row_known_reg)
            begin
                old_line[w].valid = 1'b0;
                old_line[w].age   = '0;
            end
            in_use[w]    = (w == 0) || (w < ways_reg);
            hit_vec[w]   = in_use[w] && old_line[w].valid && (old_line[w].tag == tag_reg);
            empty_vec[w] = in_use[w] && !old_line[w].valid;
        end

        any_hit   = |hit_vec;
        any_empty = |empty_vec;
        hit_way   = '0;
        empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_IDX_W'(w);
            end
            if (empty_vec[w])
            begin
                empty_way = WAY_IDX_W'(w);
            end
        end

        victim_way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && (old_line[w].age > old_line[victim_way].age))
            begin
                victim_way = WAY_IDX_W'(w);
            end
        end
        target_way = any_empty ? empty_way : victim_way;
        hit_age    = old_line[hit_way].age;

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            new_line[w] = old_line[w];
            if (any_hit)
            begin
                if (in_use[w] && old_line[w].valid && (old_line[w].age < hit_age))
                begin
                    new_line[w].age = age_inc(old_line[w].age);
                end
                if (WAY_IDX_W'(w) == hit_way)
                begin
                    new_line[w].age = '0;
                end
            end
            else
            begin
                if (WAY_IDX_W'(w) == target_way)
                begin
                    new_line[w].valid = 1'b1;
                    new_line[w].age   = '0;
                    new_line[w].tag   = tag_reg;
                end
                else if (in_use[w] && old_line[w].valid)
                begin
                    new_line[w].age = age_inc(old_line[w].age);
                end
            end
            wr_row[w*LINE_W +: LINE_W] = new_line[w];
        end

        missed  = !any_hit;
        evicted = !any_hit && !any_empty;
        if (any_hit)
        begin
            hits = modify_reg ? HITS_W'(2) : HITS_W'(1);
        end
        else
        begin
            hits = modify_reg ? HITS_W'(1) : HITS_W'(0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rd_row_reg <= mem[set_idx];
            modify_reg <= (req.opcode == OP_MODIFY);
            set_reg    <= set_idx;
            tag_reg    <= tag_in;
        end
        if (cmd.commit)
        begin
            mem[set_reg] <= wr_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_written_reg <= '0;
            row_known_reg   <= 1'b0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                row_known_reg <= row_written_reg[set_idx];
            end
            if (cmd.commit)
            begin
                row_written_reg[set_reg] <= 1'b1;
                hit_total_reg   <= hit_total_reg + TOTAL_W'(hits);
                miss_total_reg  <= miss_total_reg + TOTAL_W'(missed);
                evict_total_reg <= evict_total_reg + TOTAL_W'(evicted);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.hits            <= hits;
            rsp_reg.missed          <= missed;
            rsp_reg.evicted         <= evicted;
            rsp_reg.total_hits      <= hit_total_reg + TOTAL_W'(hits);
            rsp_reg.total_misses    <= miss_total_reg + TOTAL_W'(missed);
            rsp_reg.total_evictions <= evict_total_reg + TOTAL_W'(evicted);
        end
    end

    assign rsp = rsp_reg;

endmodule

[rtl/salc_checker.sv]
`timescale 1ns / 1ps

module salc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input salc_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input salc_pkg::rsp_t rsp
);
    import salc_pkg::*;

    // a stalled rsp transaction holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // a cache access keeps the block busy for the following cycle
    a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.opcode != OP_FETCH) |=> !req_ready)
        else $error("req taken during a lookup");

    // a new rsp only appears after a lookup cycle
    a_rsp_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("rsp without a lookup");

    // outcome fields agree: evictions only on misses, hits in range and nonzero unless missed
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.evicted || rsp.missed) && (rsp.hits != 2'd3)
                      && (rsp.missed || (rsp.hits != 2'd0)))
        else $error("inconsistent outcome");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);
